// ----- sv/ufe_pkg.sv -----
// Shared types and constants of the sync-header frame extractor.
`default_nettype none

package ufe_pkg;

    localparam int HEADER_BYTES      = 4;
    localparam int MAX_PAYLOAD_WORDS = 4;
    localparam int STORE_BYTES       = MAX_PAYLOAD_WORDS * 4;
    localparam int MAX_RESULTS       = (HEADER_BYTES > MAX_PAYLOAD_WORDS) ?
                                       HEADER_BYTES : MAX_PAYLOAD_WORDS;

    localparam int HDR_IDX_W   = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int MATCH_W     = $clog2(HEADER_BYTES + 1);
    localparam int STORE_IDX_W = $clog2(STORE_BYTES);
    localparam int PCOUNT_W    = 5;
    localparam int RES_IDX_W   = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int WORDS_W     = 3;
    localparam int ADDR_W      = 3;

    localparam logic [31:0]        SYNC_HEADER_RST   = 32'h3108_1990;
    localparam logic [WORDS_W-1:0] PAYLOAD_WORDS_RST = 3'd4;

    typedef enum logic [1:0] {
        OUT_CONSOLE = 2'd0,
        OUT_PAYLOAD = 2'd1,
        OUT_TRUNC   = 2'd2
    } out_kind_t;

    typedef enum logic {
        IN_BYTE    = 1'b0,
        IN_TIMEOUT = 1'b1
    } in_kind_t;

    typedef enum logic {
        REG_SYNC_HEADER   = 1'b0,
        REG_PAYLOAD_WORDS = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [31:0]        sync_header;
        logic [WORDS_W-1:0] payload_words;
    } cfg_t;

    // One classified item: a burst of 1 to MAX_RESULTS results of one kind.
    typedef struct packed {
        out_kind_t                    kind;
        logic [RES_CNT_W-1:0]         count;
        logic [MAX_RESULTS-1:0][31:0] words;
    } job_t;

endpackage

`default_nettype wire

// ----- sv/ufe_regs.sv -----
// Configuration registers behind the APB-style port.
`default_nettype none

module ufe_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ufe_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output ufe_pkg::cfg_t                    cfg
);

    logic [31:0]                 sync_header_reg;
    logic [ufe_pkg::WORDS_W-1:0] payload_words_reg;
    logic                        wr_en;
    ufe_pkg::reg_idx_t           sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = ufe_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_header_reg   <= ufe_pkg::SYNC_HEADER_RST;
            payload_words_reg <= ufe_pkg::PAYLOAD_WORDS_RST;
        end
        else if (wr_en)
        begin
            unique case (sel)
                ufe_pkg::REG_SYNC_HEADER:   sync_header_reg   <= pwdata;
                ufe_pkg::REG_PAYLOAD_WORDS:
                    payload_words_reg <= pwdata[ufe_pkg::WORDS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            ufe_pkg::REG_SYNC_HEADER:   prdata = sync_header_reg;
            ufe_pkg::REG_PAYLOAD_WORDS:
                prdata = {{(32-ufe_pkg::WORDS_W){1'b0}}, payload_words_reg};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.sync_header   = sync_header_reg;
    assign cfg.payload_words = payload_words_reg;

endmodule

`default_nettype wire

// ----- sv/ufe_front.sv -----
// Front part: header search, payload collection and job classification.
`default_nettype none

module ufe_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ufe_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    input  wire logic          in_kind,
    input  wire logic [7:0]    in_byte,
    input  wire logic          queue_full,
    output logic               in_ready,
    output logic               job_valid,
    output ufe_pkg::job_t      job
);

    localparam int HB = ufe_pkg::HEADER_BYTES;
    localparam int SB = ufe_pkg::STORE_BYTES;
    localparam int MW = ufe_pkg::MAX_PAYLOAD_WORDS;

    logic                          in_payload_reg, in_payload_next;
    logic [ufe_pkg::MATCH_W-1:0]   match_count_reg, match_count_next;
    logic [ufe_pkg::PCOUNT_W-1:0]  payload_count_reg, payload_count_next;
    logic [7:0]                    held_reg [HB];
    logic [7:0]                    held_next [HB];
    logic [7:0]                    store_reg [SB];
    logic [7:0]                    store_next [SB];

    logic                          accept;
    logic [ufe_pkg::HDR_IDX_W-1:0] idx;
    logic [7:0]                    want;
    logic [ufe_pkg::PCOUNT_W-1:0]  words_used;
    logic [ufe_pkg::PCOUNT_W-1:0]  bytes_needed;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Clamp the configured length to 1..MAX_PAYLOAD_WORDS.
    always_comb
    begin
        if (cfg.payload_words == '0)
            words_used = ufe_pkg::PCOUNT_W'(1);
        else if (ufe_pkg::PCOUNT_W'(cfg.payload_words) > ufe_pkg::PCOUNT_W'(MW))
            words_used = ufe_pkg::PCOUNT_W'(MW);
        else
            words_used = ufe_pkg::PCOUNT_W'(cfg.payload_words);
        bytes_needed = ufe_pkg::PCOUNT_W'(words_used << 2);
    end

    always_comb
    begin
        if (match_count_reg >= ufe_pkg::MATCH_W'(HB))
            idx = ufe_pkg::HDR_IDX_W'(HB - 1);
        else
            idx = match_count_reg[ufe_pkg::HDR_IDX_W-1:0];
        want = cfg.sync_header[8*idx +: 8];
    end

    always_comb
    begin
        in_payload_next    = in_payload_reg;
        match_count_next   = match_count_reg;
        payload_count_next = payload_count_reg;
        held_next          = held_reg;
        store_next         = store_reg;
        job_valid          = 1'b0;
        job.kind           = ufe_pkg::OUT_CONSOLE;
        job.count          = '0;
        job.words          = '0;

        if (accept)
        begin
            if (!in_payload_reg)
            begin
                if (in_kind == ufe_pkg::IN_TIMEOUT)
                begin
                    job_valid        = (match_count_reg != '0);
                    job.count        = ufe_pkg::RES_CNT_W'(match_count_reg);
                    match_count_next = '0;
                    for (int i = 0; i < HB; i++)
                        job.words[i] = {24'd0, held_reg[i]};
                end
                else
                begin
                    held_next[idx] = in_byte;
                    if (in_byte != want)
                    begin
                        // Mismatch: forward everything held, the failing byte too.
                        job_valid        = 1'b1;
                        job.count        = ufe_pkg::RES_CNT_W'({1'b0, idx} + 1'b1);
                        match_count_next = '0;
                        for (int i = 0; i < HB; i++)
                            job.words[i] = {24'd0, held_next[i]};
                    end
                    else if (idx == ufe_pkg::HDR_IDX_W'(HB - 1))
                    begin
                        match_count_next   = '0;
                        in_payload_next    = 1'b1;
                        payload_count_next = '0;
                    end
                    else
                    begin
                        match_count_next = ufe_pkg::MATCH_W'({1'b0, idx} + 1'b1);
                    end
                end
            end
            else
            begin
                if (in_kind == ufe_pkg::IN_TIMEOUT)
                begin
                    job_valid          = 1'b1;
                    job.kind           = ufe_pkg::OUT_TRUNC;
                    job.count          = ufe_pkg::RES_CNT_W'(1);
                    job.words[0]       = {{(32-ufe_pkg::PCOUNT_W){1'b0}}, payload_count_reg};
                    in_payload_next    = 1'b0;
                    payload_count_next = '0;
                end
                else
                begin
                    if (payload_count_reg < ufe_pkg::PCOUNT_W'(SB))
                    begin
                        store_next[payload_count_reg[ufe_pkg::STORE_IDX_W-1:0]] = in_byte;
                        payload_count_next = payload_count_reg + 1'b1;
                    end
                    if (payload_count_next >= bytes_needed)
                    begin
                        job_valid          = 1'b1;
                        job.kind           = ufe_pkg::OUT_PAYLOAD;
                        job.count          = ufe_pkg::RES_CNT_W'(words_used);
                        in_payload_next    = 1'b0;
                        payload_count_next = '0;
                        for (int i = 0; i < MW; i++)
                            job.words[i] = {store_next[4*i+3], store_next[4*i+2],
                                            store_next[4*i+1], store_next[4*i]};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg    <= 1'b0;
            match_count_reg   <= '0;
            payload_count_reg <= '0;
        end
        else
        begin
            in_payload_reg    <= in_payload_next;
            match_count_reg   <= match_count_next;
            payload_count_reg <= payload_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg  <= held_next;
        store_reg <= store_next;
    end

endmodule

`default_nettype wire

// ----- sv/ufe_queue.sv -----
// Two-entry job queue between the front and back parts.
`default_nettype none

module ufe_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ufe_pkg::job_t push_job,
    input  wire logic          pop,
    output logic               full,
    output logic               empty,
    output ufe_pkg::job_t      head
);

    ufe_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// ----- sv/ufe_back.sv -----
// Back part: expands each job into results and drives the output register.
`default_nettype none

module ufe_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_empty,
    input  wire ufe_pkg::job_t job,
    output logic               job_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [1:0]         out_kind,
    output logic [31:0]        out_value,
    output logic               out_last
);

    logic [ufe_pkg::RES_IDX_W-1:0] idx_reg, idx_next;
    logic                          valid_reg, valid_next;
    logic [1:0]                    kind_reg;
    logic [31:0]                   value_reg;
    logic                          last_reg;
    logic                          load;
    logic                          is_last;

    // The output register takes a new result whenever a job is waiting and the register is empty or being drained.
    assign load    = !job_empty && (!valid_reg || out_ready);
    assign is_last = (ufe_pkg::RES_CNT_W'(idx_reg) + 1'b1 == job.count);
    assign job_pop = load && is_last;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? '0 : idx_reg + 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= job.kind;
            value_reg <= job.words[idx_reg];
            last_reg  <= is_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

// ----- sv/uart_header_frame_extractor.sv -----
// Top level of the sync-header frame extractor.
//
// Input stream: s_tdata carries a received serial byte, s_tuser says whether the
// item is a byte (0) or a read timeout (1). Bytes are matched against a 4-byte
// sync header; on a mismatch or a timeout during the search the bytes held so
// far are forwarded as console bytes. After a full header the configured number
// of payload words is collected and sent as little-endian 32-bit words, or a
// timeout sends one truncated-message result carrying the byte count.
// Output stream: m_tuser is the result kind, m_tdata the value, m_tlast marks
// the final result caused by one input item.
// The first result of an item is registered in a job queue entry and then in
// the output register. Throughput: one input item per cycle while the job
// queue is not full, and one result per cycle while the receiver takes them;
// the results of one item leave in turn, and the two-entry job queue between
// the classifier and the output stage absorbs such bursts.
// When the receiver stalls, the output register holds and the queue fills;
// s_tready drops only once both queue entries are taken.
// Reset clears the search state, the queue and the output register and loads
// the default header and payload length; no clearing pass is needed.
`default_nettype none

module uart_header_frame_extractor (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] rx_byte
    input  wire logic                        s_tuser,   // [0] kind
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [31:0]                 m_tdata,   // [31:0] out_value
    output logic      [1:0]                  m_tuser,   // [1:0] out_kind
    output logic                             m_tlast,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ufe_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    ufe_pkg::cfg_t cfg;
    ufe_pkg::job_t push_job;
    ufe_pkg::job_t head_job;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    ufe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ufe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_kind    (s_tuser),
        .in_byte    (s_tdata),
        .queue_full (full),
        .in_ready   (s_tready),
        .job_valid  (push),
        .job        (push_job)
    );

    ufe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head_job)
    );

    ufe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (empty),
        .job       (head_job),
        .job_pop   (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_value (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- sv/ufe_checker.sv -----
// Port-level checks of the frame extractor and their binding to the top level.
`default_nettype none

module ufe_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast,
    input wire logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ufe_pkg::OUT_CONSOLE) || (m_tuser == ufe_pkg::OUT_PAYLOAD)
                     || (m_tuser == ufe_pkg::OUT_TRUNC))
        else $error("unknown result kind");

    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ufe_pkg::OUT_TRUNC) |-> m_tlast)
        else $error("truncated result not marked last");

    a_console_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ufe_pkg::OUT_CONSOLE) |-> (m_tdata[31:8] == 24'd0))
        else $error("console result wider than a byte");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("configuration port not ready");

endmodule

bind uart_header_frame_extractor ufe_checker u_ufe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .pready   (pready)
);

`default_nettype wire
